// ----- hw/rtl/dfr_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package dfr_pkg;

  localparam int unsigned COUNT_WIDTH = 24;
  localparam int unsigned LIMIT_W     = 24;
  localparam int unsigned CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam int unsigned HDR_W       = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'h100000;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [HDR_W-1:0] EXT16_BYTES    = 4'd2;
  localparam logic [HDR_W-1:0] EXT64_BYTES    = 4'd8;
  localparam logic [HDR_W-1:0] MASK_KEY_BYTES = 4'd4;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TEXT     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_PONG     = 3'd2,
    KIND_CLOSE    = 3'd3,
    KIND_OVERSIZE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/websocket_frame_deframer_top.sv -----
// A result is written into the two-entry output buffer and is offered on out_tvalid from there.
// Throughput: one byte per cycle while the result side keeps taking results.
// in_tready is decoded from the registered occupancy of the two-entry output buffer.
// Reset (rst_n low, synchronous): parser awaits a first header byte, not halted,
// payload limit returns to 1048576, output buffer empties.
`default_nettype none
module websocket_frame_deframer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [dfr_pkg::LIMIT_W-1:0] cfg_wr_data,  // max_payload_bytes
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [7:0]                  in_tdata,     // [7:0] rx_byte
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [7:0]                  out_tdata,    // [7:0] out_byte
  output      logic [2:0]                  out_tuser,    // [2:0] out_kind
  output      logic                        out_tlast     // last_of_message
);

  logic             in_accept;
  logic             res_valid;
  dfr_pkg::result_t res;
  dfr_pkg::result_t buf_data;

  assign in_accept = in_tvalid && in_tready;

  dfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (in_accept),
    .byte_data   (in_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  dfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (in_tready),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (buf_data)
  );

  assign out_tdata = buf_data.data;
  assign out_tuser = buf_data.kind;
  assign out_tlast = buf_data.last;

  a_res_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_accept)
    else $error("result produced without an input transaction");

  a_empty_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("empty output buffer stalls input");

  a_non_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != dfr_pkg::KIND_TEXT) |-> (!out_tlast && out_tdata == 8'h00))
    else $error("non-text result carries payload or last mark");

  a_halt_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready &&
     (out_tuser == dfr_pkg::KIND_CLOSE || out_tuser == dfr_pkg::KIND_OVERSIZE))
    |=> !out_tvalid)
    else $error("result follows a close or oversize report");

endmodule
`default_nettype wire

// ----- hw/rtl/dfr_parser.sv -----
// Frame header decoder and payload counter, one byte per cycle.
`default_nettype none
module dfr_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [dfr_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  wire logic                          byte_valid,
  input  wire logic [7:0]                    byte_data,
  output      logic                          res_valid,
  output      dfr_pkg::result_t              res
);

  localparam int unsigned CntW = dfr_pkg::COUNT_WIDTH;
  localparam int unsigned CmpW = dfr_pkg::CMP_W;
  localparam int unsigned HdrW = dfr_pkg::HDR_W;

  dfr_pkg::phase_t                 phase_r, phase_nxt;
  logic [3:0]                      opcode_r, opcode_nxt;
  logic                            mask_r, mask_nxt;
  logic [HdrW-1:0]                 hdr_left_r, hdr_left_nxt;
  logic [CntW-1:0]                 acc_r, acc_nxt;
  logic                            acc_ovf_r, acc_ovf_nxt;
  logic [CntW-1:0]                 pl_left_r, pl_left_nxt;
  logic                            halted_r, halted_nxt;
  logic [dfr_pkg::LIMIT_W-1:0]     limit_r;

  logic                            step;
  logic [6:0]                      len7;
  logic [CntW+7:0]                 acc_wide;
  logic [CntW-1:0]                 ext_acc;
  logic                            ext_ovf;
  logic [HdrW-1:0]                 hdr_dec;
  logic                            hdr_done;
  logic [CntW-1:0]                 fin_len;
  logic                            fin_ovf;
  logic                            fin_mask;
  logic                            oversize;
  logic [CntW-1:0]                 pl_dec;
  logic                            pl_last;
  logic                            zero_valid;
  dfr_pkg::kind_t                  zero_kind;
  logic                            end_valid;
  dfr_pkg::kind_t                  end_kind;
  logic                            ext_short;

  assign step      = byte_valid && !halted_r;
  assign len7      = byte_data[6:0];
  assign ext_short = (len7 != dfr_pkg::LEN_CODE_EXT16) && (len7 != dfr_pkg::LEN_CODE_EXT64);
  assign acc_wide  = {acc_r, byte_data};
  assign ext_acc   = acc_wide[CntW-1:0];
  assign ext_ovf   = acc_ovf_r | (|acc_wide[CntW+7:CntW]);
  assign hdr_dec   = hdr_left_r - HdrW'(1);
  assign hdr_done  = (hdr_dec == '0);
  assign pl_dec    = pl_left_r - CntW'(1);
  assign pl_last   = (pl_dec == '0);

  assign fin_len   = (phase_r == dfr_pkg::PH_SECOND) ? CntW'(len7) : ext_acc;
  assign fin_ovf   = (phase_r == dfr_pkg::PH_SECOND) ? 1'b0 : ext_ovf;
  assign fin_mask  = (phase_r == dfr_pkg::PH_SECOND) ? byte_data[7] : mask_r;
  assign oversize  = fin_ovf || (CmpW'(fin_len) > CmpW'(limit_r));

  // Result of a frame that ends with its header, and of a frame's final byte.
  always_comb begin
    end_valid = 1'b0;
    end_kind  = dfr_pkg::KIND_PONG;
    case (opcode_r)
      dfr_pkg::OP_PING: begin
        end_valid = 1'b1;
        end_kind  = dfr_pkg::KIND_PONG;
      end
      dfr_pkg::OP_CLOSE: begin
        end_valid = 1'b1;
        end_kind  = dfr_pkg::KIND_CLOSE;
      end
      default: begin
        end_valid = 1'b0;
      end
    endcase
    if (opcode_r == dfr_pkg::OP_TEXT) begin
      zero_valid = 1'b1;
      zero_kind  = dfr_pkg::KIND_EMPTY;
    end else begin
      zero_valid = end_valid;
      zero_kind  = end_kind;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    hdr_left_nxt = hdr_left_r;
    acc_nxt      = acc_r;
    acc_ovf_nxt  = acc_ovf_r;
    pl_left_nxt  = pl_left_r;
    halted_nxt   = halted_r;
    if (step) begin
      case (phase_r)
        dfr_pkg::PH_SECOND, dfr_pkg::PH_EXT: begin
          if (phase_r == dfr_pkg::PH_SECOND) begin
            mask_nxt    = byte_data[7];
            acc_nxt     = '0;
            acc_ovf_nxt = 1'b0;
            if (len7 == dfr_pkg::LEN_CODE_EXT16) begin
              hdr_left_nxt = dfr_pkg::EXT16_BYTES;
              phase_nxt    = dfr_pkg::PH_EXT;
            end else if (len7 == dfr_pkg::LEN_CODE_EXT64) begin
              hdr_left_nxt = dfr_pkg::EXT64_BYTES;
              phase_nxt    = dfr_pkg::PH_EXT;
            end
          end else begin
            acc_nxt      = ext_acc;
            acc_ovf_nxt  = ext_ovf;
            hdr_left_nxt = hdr_dec;
          end
          if ((phase_r == dfr_pkg::PH_SECOND && ext_short) ||
              (phase_r == dfr_pkg::PH_EXT && hdr_done)) begin
            if (oversize) begin
              halted_nxt = 1'b1;
              phase_nxt  = dfr_pkg::PH_FIRST;
            end else begin
              pl_left_nxt = fin_len;
              if (fin_mask) begin
                hdr_left_nxt = dfr_pkg::MASK_KEY_BYTES;
                phase_nxt    = dfr_pkg::PH_MASK;
              end else if (fin_len == '0) begin
                phase_nxt = dfr_pkg::PH_FIRST;
                if (opcode_r == dfr_pkg::OP_CLOSE) halted_nxt = 1'b1;
              end else begin
                phase_nxt = dfr_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        dfr_pkg::PH_MASK: begin
          hdr_left_nxt = hdr_dec;
          if (hdr_done) begin
            if (pl_left_r == '0) begin
              phase_nxt = dfr_pkg::PH_FIRST;
              if (opcode_r == dfr_pkg::OP_CLOSE) halted_nxt = 1'b1;
            end else begin
              phase_nxt = dfr_pkg::PH_PAYLOAD;
            end
          end
        end
        dfr_pkg::PH_PAYLOAD: begin
          pl_left_nxt = pl_dec;
          if (pl_last) begin
            phase_nxt = dfr_pkg::PH_FIRST;
            if (opcode_r == dfr_pkg::OP_CLOSE) halted_nxt = 1'b1;
          end
        end
        default: begin
          opcode_nxt = byte_data[3:0];
          phase_nxt  = dfr_pkg::PH_SECOND;
        end
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res.kind  = dfr_pkg::KIND_TEXT;
    res.data  = 8'h00;
    res.last  = 1'b0;
    if (step) begin
      case (phase_r)
        dfr_pkg::PH_SECOND, dfr_pkg::PH_EXT: begin
          if ((phase_r == dfr_pkg::PH_SECOND && ext_short) ||
              (phase_r == dfr_pkg::PH_EXT && hdr_done)) begin
            if (oversize) begin
              res_valid = 1'b1;
              res.kind  = dfr_pkg::KIND_OVERSIZE;
            end else if (!fin_mask && fin_len == '0) begin
              res_valid = zero_valid;
              res.kind  = zero_kind;
            end
          end
        end
        dfr_pkg::PH_MASK: begin
          if (hdr_done && pl_left_r == '0) begin
            res_valid = zero_valid;
            res.kind  = zero_kind;
          end
        end
        dfr_pkg::PH_PAYLOAD: begin
          if (opcode_r == dfr_pkg::OP_TEXT) begin
            res_valid = 1'b1;
            res.kind  = dfr_pkg::KIND_TEXT;
            res.data  = byte_data;
            res.last  = pl_last;
          end else if (pl_last) begin
            res_valid = end_valid;
            res.kind  = end_kind;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dfr_pkg::PH_FIRST;
      opcode_r   <= '0;
      mask_r     <= 1'b0;
      hdr_left_r <= '0;
      acc_r      <= '0;
      acc_ovf_r  <= 1'b0;
      pl_left_r  <= '0;
      halted_r   <= 1'b0;
      limit_r    <= dfr_pkg::LIMIT_RESET;
    end else begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      mask_r     <= mask_nxt;
      hdr_left_r <= hdr_left_nxt;
      acc_r      <= acc_nxt;
      acc_ovf_r  <= acc_ovf_nxt;
      pl_left_r  <= pl_left_nxt;
      halted_r   <= halted_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dfr_out_buf.sv -----
// Two-entry output buffer with registered ready toward the parser side.
`default_nettype none
module dfr_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire dfr_pkg::result_t push_data,
  output      logic             space,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      dfr_pkg::result_t pop_data
);

  dfr_pkg::result_t ent_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != 2'd0);
  assign space     = (count_r != 2'd2);
  assign pop_data  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire
